// ===== hw/rtl/tile_cache_farthest_eviction_defines.svh =====
// ============================================================================
// Tile cache assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef TILE_CACHE_FARTHEST_EVICTION_DEFINES_SVH
`define TILE_CACHE_FARTHEST_EVICTION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tcfe_pkg.sv =====
// ============================================================================
// Tile cache package
// Widths, status codes and defaults shared by the tile cache files.
// ============================================================================
package tcfe_pkg;

	localparam int CACHE_SLOTS_DEF = 16;
	localparam int MAP_TILES       = 64;
	localparam int COORD_W         = $clog2(MAP_TILES);
	localparam int TILE_W          = 8;
	localparam int SLOT_W          = 4;
	localparam int STATUS_W        = 2;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COORD_W-1:0]  coord_t;

	localparam status_t ST_NOT_IN_MAP = 2'd0;
	localparam status_t ST_HIT        = 2'd1;
	localparam status_t ST_FILLED     = 2'd2;
	localparam status_t ST_EVICTED    = 2'd3;

endpackage

// ===== hw/rtl/tcfe_req_if.sv =====
// ============================================================================
// Tile cache request channel
// Valid/ready channel that carries one tile request item.
// ============================================================================
interface tcfe_req_if import tcfe_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [TILE_W-1:0] tile_x;
	logic signed [TILE_W-1:0] tile_z;
	logic                     tile_in_map;
	coord_t                   center_x;
	coord_t                   center_z;

	modport source (
		output valid, tile_x, tile_z, tile_in_map, center_x, center_z,
		input  ready
	);

	modport sink (
		input  valid, tile_x, tile_z, tile_in_map, center_x, center_z,
		output ready
	);

endinterface

// ===== hw/rtl/tcfe_rsp_if.sv =====
// ============================================================================
// Tile cache response channel
// Valid/ready channel that carries one lookup result item.
// ============================================================================
interface tcfe_rsp_if import tcfe_pkg::*; ();

	logic              valid;
	logic              ready;
	status_t           status;
	logic [SLOT_W-1:0] slot;
	coord_t            evicted_x;
	coord_t            evicted_z;

	modport source (
		output valid, status, slot, evicted_x, evicted_z,
		input  ready
	);

	modport sink (
		input  valid, status, slot, evicted_x, evicted_z,
		output ready
	);

endinterface

// ===== hw/rtl/tile_cache_farthest_eviction.sv =====
// ============================================================================
// Tile cache with farthest-from-center eviction
// Fully associative cache of map tile coordinates held in one synchronous RAM.
// ============================================================================
// Usage: a request item on req names a tile (tile_x, tile_z), whether the map
// holds it, and the current center tile. Every request gives exactly one
// result item on rsp: not in map, hit, filled an empty slot, or evicted the
// slot farthest (Manhattan distance) from the center and replaced it.
// Sequencing: a request outside the map or absent goes straight to the
// result stage after acceptance. A lookup scans the tag RAM once, one slot
// read per cycle, and a hit or a fill goes to the output register when that
// scan closes. When every slot is full a second scan of the same length
// computes distances before the eviction result loads. The next request is
// taken the cycle after the result loads, so the pace of lookups is set by
// the single read port of the tag RAM, and one item is in work at a time.
// Reset clears all slot valid bits, the sequencer and the output valid flag;
// the RAM contents are left as they are and are only read from valid slots.
// Stalls: the result sits in an output register. While it waits for rsp.ready
// the block already accepts and works on the next request; it holds that
// request's result until the output register frees up.
// ============================================================================
`include "tile_cache_farthest_eviction_defines.svh"

module tile_cache_farthest_eviction import tcfe_pkg::*; #(
	parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tcfe_req_if.sink   req,
	tcfe_rsp_if.source rsp
);

	localparam int IW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int CW = $clog2(CACHE_SLOTS + 1);
	localparam int DW = COORD_W + 1;
	localparam int EW = 2 * COORD_W;

	// Sequencer codes.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MATCH = 2'd1;
	localparam logic [1:0] S_EVICT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;

	// Tag RAM: {column, row} per slot. Validity lives in flip-flops.
	logic [EW-1:0]          mem [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] valid_q;

	// Scan counter and the RAM read pipeline stage.
	logic [CW-1:0] cnt_q;
	logic          rd_issue;
	logic [IW-1:0] rd_addr;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [EW-1:0] rd_data_s1;
	logic          scan_end;

	// The request under work.
	coord_t col_q, row_q, cx_q, cz_q;
	logic   req_in_map;

	// First scan: hit and lowest empty slot.
	logic          hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;

	// Second scan: farthest slot so far.
	logic [DW-1:0] slot_dist;
	logic [DW-1:0] best_q;
	logic [IW-1:0] best_idx_q;
	logic [EW-1:0] best_data_q;
	logic          take_best;

	// Memory write port.
	logic          mem_we;
	logic [IW-1:0] mem_wa;

	// Finished result and the output register.
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	coord_t            res_ex_q, res_ez_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	coord_t            out_ex_q, out_ez_q;
	logic              out_load;

	// A tile lies in the map when both signed coordinates fall in 0..63.
	assign req_in_map = req.tile_in_map
		&& (req.tile_x[TILE_W-1:COORD_W] == '0)
		&& (req.tile_z[TILE_W-1:COORD_W] == '0);

	assign req.ready = (state_q == S_IDLE);

	assign rd_issue = ((state_q == S_MATCH) || (state_q == S_EVICT))
		&& (cnt_q != CW'(CACHE_SLOTS));
	assign rd_addr  = cnt_q[IW-1:0];
	// The scan is over once every slot was issued and the last read came back.
	assign scan_end = (cnt_q == CW'(CACHE_SLOTS)) && !rd_vld_s1;

	// Manhattan distance of the slot just read from the request's center.
	always_comb begin
		coord_t ec, er;
		coord_t dc, dr;
		ec = rd_data_s1[EW-1:COORD_W];
		er = rd_data_s1[COORD_W-1:0];
		dc = (ec > cx_q) ? (ec - cx_q) : (cx_q - ec);
		dr = (er > cz_q) ? (er - cz_q) : (cz_q - er);
		slot_dist = {1'b0, dc} + {1'b0, dr};
	end

	// Slot 0 always seeds the search; later slots win only when strictly farther.
	assign take_best = rd_vld_s1 && ((rd_idx_s1 == '0) || (slot_dist > best_q));

	assign mem_we = ((state_q == S_MATCH) && scan_end && !hit_q && free_q)
		|| ((state_q == S_EVICT) && scan_end);
	assign mem_wa = (state_q == S_EVICT) ? best_idx_q : free_idx_q;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Tag RAM with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= {col_q, row_q};
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (mem_we) begin
				valid_q[mem_wa] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= req_in_map ? S_MATCH : S_DONE;
					end
				end
				S_MATCH: begin
					if (rd_vld_s1) begin
						if (valid_q[rd_idx_s1]) begin
							if (rd_data_s1 == {col_q, row_q}) begin
								hit_q <= 1'b1;
							end
						end else begin
							free_q <= 1'b1;
						end
					end
					if (scan_end) begin
						if (hit_q || free_q) begin
							state_q <= S_DONE;
						end else begin
							cnt_q   <= '0;
							state_q <= S_EVICT;
						end
					end
				end
				S_EVICT: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (take_best && (state_q == S_EVICT)) begin
			best_q      <= slot_dist;
			best_idx_q  <= rd_idx_s1;
			best_data_q <= rd_data_s1;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_ex_q     <= res_ex_q;
			out_ez_q     <= res_ez_q;
		end
		case (state_q)
			S_IDLE: begin
				col_q        <= req.tile_x[COORD_W-1:0];
				row_q        <= req.tile_z[COORD_W-1:0];
				cx_q         <= req.center_x;
				cz_q         <= req.center_z;
				res_status_q <= ST_NOT_IN_MAP;
				res_slot_q   <= '0;
				res_ex_q     <= '0;
				res_ez_q     <= '0;
			end
			S_MATCH: begin
				// Only the first match and the first empty slot are kept.
				if (rd_vld_s1) begin
					if (valid_q[rd_idx_s1]) begin
						if (!hit_q && (rd_data_s1 == {col_q, row_q})) begin
							hit_idx_q <= rd_idx_s1;
						end
					end else if (!free_q) begin
						free_idx_q <= rd_idx_s1;
					end
				end
				if (scan_end) begin
					if (hit_q) begin
						res_status_q <= ST_HIT;
						res_slot_q   <= SLOT_W'(hit_idx_q);
					end else if (free_q) begin
						res_status_q <= ST_FILLED;
						res_slot_q   <= SLOT_W'(free_idx_q);
					end
				end
			end
			S_EVICT: begin
				if (scan_end) begin
					res_status_q <= ST_EVICTED;
					res_slot_q   <= SLOT_W'(best_idx_q);
					res_ex_q     <= best_data_q[EW-1:COORD_W];
					res_ez_q     <= best_data_q[COORD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.slot      = out_slot_q;
	assign rsp.evicted_x = out_ex_q;
	assign rsp.evicted_z = out_ez_q;

	// Eviction is only reached with every slot occupied.
	`TCFE_ASSERT_SAME(a_evict_full, state_q == S_EVICT, &valid_q, "eviction scan with an empty slot")
	// Slots never become empty again outside reset.
	`TCFE_ASSERT_NEXT(a_valid_sticky, 1'b1, (valid_q & $past(valid_q)) == $past(valid_q), "slot valid bit dropped")
	// A recorded hit always points at an occupied slot.
	`TCFE_ASSERT_SAME(a_hit_valid, (state_q == S_MATCH) && hit_q, valid_q[hit_idx_q], "hit on an empty slot")
	// Evicted coordinates are zero unless the result is an eviction.
	`TCFE_ASSERT_SAME(a_ev_zero, rsp.valid && (rsp.status != ST_EVICTED), (rsp.evicted_x == '0) && (rsp.evicted_z == '0), "evicted fields set without eviction")

endmodule

// ===== tb/sv/tile_cache_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile cache lookup checker
// Watches the request and result channels of the tile cache, predicts the
// result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module tile_cache_lookup_checker import tcfe_pkg::*; #(
	parameter int SLOTS = CACHE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tcfe_req_if         req,
	tcfe_rsp_if         rsp,
	output int unsigned failures,
	output int unsigned outstanding
);

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		coord_t            evicted_x;
		coord_t            evicted_z;
	} lookup_result_t;

	// Shadow copy of the cache contents.
	bit     held[SLOTS];
	coord_t held_col[SLOTS];
	coord_t held_row[SLOTS];

	lookup_result_t expected_lookups[$];
	int unsigned    result_index;

	task automatic report_mismatch(input string msg);
		$display("[%0t] result %0d: %s", $time, result_index, msg);
		failures++;
	endtask

	// Works out the result of one request and updates the shadow cache.
	function automatic lookup_result_t predict_lookup(
		input logic signed [TILE_W-1:0] tx,
		input logic signed [TILE_W-1:0] tz,
		input logic                     present,
		input coord_t                   cx,
		input coord_t                   cz
	);
		lookup_result_t r;
		coord_t         col;
		coord_t         row;
		int             free_slot;
		int             best_dist;
		int             best_slot;
		int             slot_dist;
		bit             found;
		r = '0;
		r.status = ST_NOT_IN_MAP;
		if (tx < 0 || tx >= MAP_TILES || tz < 0 || tz >= MAP_TILES || !present)
			return r;
		col = tx[COORD_W-1:0];
		row = tz[COORD_W-1:0];
		free_slot = -1;
		found = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (held[i]) begin
				if (!found && held_col[i] == col && held_row[i] == row) begin
					found = 1'b1;
					r.slot = SLOT_W'(i);
				end
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (found) begin
			r.status = ST_HIT;
			return r;
		end
		if (free_slot >= 0) begin
			r.status = ST_FILLED;
			best_slot = free_slot;
		end else begin
			// Strictly greater distance wins, so ties keep the lowest index.
			best_dist = 0;
			best_slot = 0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_dist = ((held_col[i] > cx) ? int'(held_col[i]) - int'(cx)
					: int'(cx) - int'(held_col[i]))
					+ ((held_row[i] > cz) ? int'(held_row[i]) - int'(cz)
					: int'(cz) - int'(held_row[i]));
				if (slot_dist > best_dist) begin
					best_dist = slot_dist;
					best_slot = i;
				end
			end
			r.status = ST_EVICTED;
			r.evicted_x = held_col[best_slot];
			r.evicted_z = held_row[best_slot];
		end
		r.slot = SLOT_W'(best_slot);
		held[best_slot] = 1'b1;
		held_col[best_slot] = col;
		held_row[best_slot] = row;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			expected_lookups.delete();
			foreach (held[i]) held[i] = 1'b0;
			result_index = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result arrived with no request outstanding");
				end else begin
					want = expected_lookups.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.slot !== want.slot)
						report_mismatch($sformatf("slot %0d, expected %0d",
							rsp.slot, want.slot));
					if (rsp.evicted_x !== want.evicted_x)
						report_mismatch($sformatf("evicted_x %0d, expected %0d",
							rsp.evicted_x, want.evicted_x));
					if (rsp.evicted_z !== want.evicted_z)
						report_mismatch($sformatf("evicted_z %0d, expected %0d",
							rsp.evicted_z, want.evicted_z));
				end
				result_index++;
			end
			if (req.valid && req.ready)
				expected_lookups = {expected_lookups, predict_lookup(req.tile_x,
					req.tile_z, req.tile_in_map, req.center_x, req.center_z)};
			outstanding <= expected_lookups.size();
		end
	end

endmodule

// ===== tb/sv/tile_cache_farthest_eviction_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile cache with farthest eviction: testbench top
// Drives tile requests into the cache, applies random backpressure on the
// result side and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tile_cache_farthest_eviction_test;

	import tcfe_pkg::*;

	localparam int SLOTS            = CACHE_SLOTS_DEF;
	localparam int RANDOM_ITEMS     = 1575;
	// The long stall on the result side, long enough to back the block up.
	localparam int LONG_HOLD_CYCLES = 400;
	// Wait after the last result, longer than a full lookup with eviction.
	localparam int DRAIN_CYCLES     = 2 * SLOTS + 40;
	localparam int CYCLE_LIMIT      = 1000000;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          hold_request;
	bit          steady_flow;
	int unsigned fail_count;
	int unsigned results_outstanding;
	int unsigned cycle_count;

	tcfe_req_if req_ch ();
	tcfe_rsp_if rsp_ch ();

	tile_cache_farthest_eviction #(
		.CACHE_SLOTS(SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tile_cache_lookup_checker #(
		.SLOTS(SLOTS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (fail_count),
		.outstanding (results_outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offers one request and returns at the edge where it is accepted. The
	// ready value read right after the edge is the one the block sampled.
	task automatic offer_tile_request(
		input logic signed [TILE_W-1:0] x,
		input logic signed [TILE_W-1:0] z,
		input logic                     present,
		input coord_t                   cx,
		input coord_t                   cz
	);
		req_ch.valid       <= 1'b1;
		req_ch.tile_x      <= x;
		req_ch.tile_z      <= z;
		req_ch.tile_in_map <= present;
		req_ch.center_x    <= cx;
		req_ch.center_z    <= cz;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// The checker's count is a registered copy of its queue size, so step to the
	// next edge first and then wait for every expected result to come back.
	task automatic wait_for_results();
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
	endtask

	// A random gap on the request side, skipped while the flow is steady.
	task automatic maybe_pause_requests();
		if (!steady_flow && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Timeout: a run that hangs ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// Result side: ready comes and goes in random bursts. On request it holds
	// off once for a long stretch of its own counting, and while the flow is
	// steady it stays high every cycle.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (steady_flow || $urandom_range(0, 5) != 0) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// Request side: directed requests, then random traffic, then the verdict.
	initial begin
		logic signed [TILE_W-1:0] rx;
		logic signed [TILE_W-1:0] rz;
		logic                     rp;
		coord_t                   rcx;
		coord_t                   rcz;
		int                       sel;
		int                       window_x;
		int                       window_z;
		hold_request = 1'b0;
		steady_flow  = 1'b0;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.tile_x      <= '0;
		req_ch.tile_z      <= '0;
		req_ch.tile_in_map <= 1'b0;
		req_ch.center_x    <= '0;
		req_ch.center_z    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests outside the map: each coordinate below and above the
		// valid range, and a tile that the map does not hold.
		offer_tile_request(-8'sd128, 8'sd0, 1'b1, 6'd0, 6'd0);
		offer_tile_request(8'sd127, 8'sd5, 1'b1, 6'd63, 6'd63);
		offer_tile_request(8'sd64, 8'sd0, 1'b1, 6'd0, 6'd0);
		offer_tile_request(8'sd0, -8'sd1, 1'b1, 6'd0, 6'd0);
		offer_tile_request(8'sd0, 8'sd64, 1'b1, 6'd0, 6'd0);
		offer_tile_request(8'sd10, 8'sd10, 1'b0, 6'd10, 6'd10);
		// First fills at the corners of the map, then a hit on the first one.
		offer_tile_request(8'sd0, 8'sd0, 1'b1, 6'd0, 6'd0);
		offer_tile_request(8'sd63, 8'sd63, 1'b1, 6'd63, 6'd63);
		offer_tile_request(8'sd0, 8'sd0, 1'b1, 6'd32, 6'd32);
		maybe_pause_requests();
		// Fill the remaining slots along an anti-diagonal.
		for (int i = 1; i <= SLOTS - 2; i++)
			offer_tile_request(8'(4 * i), 8'(63 - 4 * i), 1'b1, 6'd0, 6'd0);
		// Full cache: the far corner is the unique farthest slot.
		offer_tile_request(8'sd63, 8'sd0, 1'b1, 6'd0, 6'd0);
		// Evict the origin tile, leaving the center tile itself in slot 0.
		offer_tile_request(8'sd63, 8'sd63, 1'b1, 6'd63, 6'd63);
		// Every other slot is at the same distance: the lowest index goes.
		offer_tile_request(8'sd62, 8'sd1, 1'b1, 6'd63, 6'd63);

		// Random traffic. Half the requests fall in a small window of tiles that
		// moves now and then, so that hits, fills and evictions all happen
		// often; the rest spread over the whole map, its corners, and noise.
		window_x = 0;
		window_z = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0) begin
				window_x = $urandom_range(0, 58);
				window_z = $urandom_range(0, 58);
			end
			if (n == 400)
				hold_request = 1'b1;
			if (n == 1000) begin
				req_ch.valid <= 1'b0;
				wait_for_results();
			end
			steady_flow = (n >= 700 && n < 850) || (n >= RANDOM_ITEMS - 200);

			sel = $urandom_range(0, 99);
			rp = 1'b1;
			if (sel < 12) begin
				rx = 8'($urandom);
				rz = 8'($urandom);
				rp = 1'($urandom_range(0, 1));
				if (rp && rx >= 0 && rx < MAP_TILES && rz >= 0 && rz < MAP_TILES) begin
					if ($urandom_range(0, 1) != 0)
						rp = 1'b0;
					else
						rz = 8'(MAP_TILES + $urandom_range(0, 63));
				end
			end else if (sel < 62) begin
				rx = 8'(window_x + $urandom_range(0, 5));
				rz = 8'(window_z + $urandom_range(0, 5));
			end else if (sel < 90) begin
				rx = 8'($urandom_range(0, 63));
				rz = 8'($urandom_range(0, 63));
			end else begin
				rx = ($urandom_range(0, 1) != 0) ? 8'sd63 : 8'sd0;
				rz = ($urandom_range(0, 1) != 0) ? 8'sd63 : 8'sd0;
			end
			rcx = ($urandom_range(0, 4) == 0)
				? (($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0)
				: 6'($urandom_range(0, 63));
			rcz = ($urandom_range(0, 4) == 0)
				? (($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0)
				: 6'($urandom_range(0, 63));

			offer_tile_request(rx, rz, rp, rcx, rcz);
			maybe_pause_requests();
		end
		req_ch.valid <= 1'b0;

		// Let every result come back, then watch a while longer for strays.
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
